// ===== src/cnsc_pkg.sv =====
// Shared types, codes and constants of the circular neighbor search block.
// Depends on nothing; the engine, the top level and the testbench refer to it by scoped names.
`default_nettype none
package cnsc_pkg;

  // Store geometry
  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned VALUE_W     = 32;

  // Word field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned QPOS_W  = 9;
  localparam int unsigned QLEN_W  = 10;
  localparam int unsigned TPOS_W  = 9;
  localparam int unsigned COST_W  = 10;
  localparam int unsigned STAT_W  = 2;

  // Rotation cost arithmetic: wide enough for both sides of the sum
  localparam int unsigned SIDE_W  = (CNT_W > QLEN_W) ? CNT_W : QLEN_W;
  localparam int unsigned SUM_W   = SIDE_W + 1;
  localparam logic [COST_W-1:0] COST_CAP = COST_W'(512);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Search modes
  typedef enum logic {
    MODE_BELOW = 1'b0,
    MODE_ABOVE = 1'b1
  } mode_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COST,
    ST_EMIT
  } state_e;

  // Input word
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic [QPOS_W-1:0]         query_position;
    logic [QLEN_W-1:0]         query_list_length;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [TPOS_W-1:0] target_position;
    logic [COST_W-1:0] move_cost;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // Shorter way around a circular list: position when at most half the
  // length, zero when past the end, else length minus position.
  function automatic logic [SIDE_W-1:0] side_cost(input logic [SIDE_W-1:0] pos,
                                                  input logic [SIDE_W-1:0] len);
    logic [SIDE_W-1:0] res;
    if (pos <= (len >> 1)) begin
      res = pos;
    end else if (pos > len) begin
      res = '0;
    end else begin
      res = len - pos;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/circular_neighbor_search_cost_core.sv =====
// Top level of the circular neighbor search block: register port, output
// register and the search engine. Depends on cnsc_pkg and cnsc_engine.
//
// The block keeps a store of up to 512 signed values. A clear word empties
// it, a load word appends one value (a load into a full store is dropped and
// reported with status 2), and a query word looks for the closest smaller
// (search_mode 0, wrapping to the maximum) or closest larger (search_mode 1,
// wrapping to the minimum) stored value, and returns its position and the
// summed rotation cost. A query scans the store through the single read port
// of the value memory, one entry per cycle. The input side stalls while a word
// is in work. Results leave through an output register, so the next word is
// taken while a result still waits downstream. The store needs no clearing
// after reset. search_mode sits at byte address 0.
`default_nettype none
module circular_neighbor_search_cost_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cnsc_pkg::in_word_t in_word_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cnsc_pkg::out_word_t     out_word_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic mode_q, mode_d;
  logic out_valid_q, out_valid_d;
  cnsc_pkg::out_word_t out_word_q, out_word_d;

  logic                res_valid;
  logic                res_take;
  cnsc_pkg::out_word_t res;
  logic                out_free;

  // register port: one register, word 0
  assign pready = 1'b1;
  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && !paddr[2]) begin
      mode_d = pwdata[0];
    end
    prdata = paddr[2] ? 32'd0 : {31'd0, mode_q};
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_take = res_valid && out_free;
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_word_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cnsc_pkg::MODE_BELOW;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  cnsc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take)
  );

endmodule
`default_nettype wire

// ===== src/cnsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module cnsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/cnsc_engine.sv =====
// Sequencer and shared compare unit: holds the value store and its fill
// count, scans the store one entry a cycle and works out the rotation cost.
// Depends on cnsc_pkg and cnsc_ram.
`default_nettype none
module cnsc_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 mode_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cnsc_pkg::in_word_t   in_word_i,
  output logic                      res_valid_o,
  output cnsc_pkg::out_word_t       res_o,
  input  wire logic                 res_take_i
);

  localparam int unsigned AW = cnsc_pkg::ADDR_W;
  localparam int unsigned CW = cnsc_pkg::CNT_W;
  localparam int unsigned VW = cnsc_pkg::VALUE_W;

  cnsc_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             dv_q, dv_d;
  logic [AW-1:0]    didx_q, didx_d;
  logic             found_q, found_d;
  logic [AW-1:0]    best_q, best_d;
  logic [AW-1:0]    ext_q, ext_d;
  logic signed [VW-1:0] best_key_q, best_key_d;
  logic signed [VW-1:0] ext_key_q, ext_key_d;
  logic signed [VW-1:0] qval_q, qval_d;
  logic [cnsc_pkg::QPOS_W-1:0] qpos_q, qpos_d;
  logic [cnsc_pkg::QLEN_W-1:0] qlen_q, qlen_d;
  cnsc_pkg::out_word_t res_q, res_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_rdata;

  // compare unit and cost path signals
  logic signed [VW-1:0] key;
  logic                 ext_upd, hit, closer;
  logic [AW-1:0]        tpos;
  logic [cnsc_pkg::SUM_W-1:0] cost_sum;

  cnsc_ram #(
    .WIDTH(VW),
    .DEPTH(cnsc_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_word_i.item_value),
    .raddr_i(issue_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnsc_pkg::ST_IDLE;
      count_q <= '0;
      dv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dv_q    <= dv_d;
      found_q <= found_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    issue_q    <= issue_d;
    didx_q     <= didx_d;
    best_q     <= best_d;
    ext_q      <= ext_d;
    best_key_q <= best_key_d;
    ext_key_q  <= ext_key_d;
    qval_q     <= qval_d;
    qpos_q     <= qpos_d;
    qlen_q     <= qlen_d;
    res_q      <= res_d;
  end

  // shared compare unit: one stored entry against the running picks
  always_comb begin
    key     = $signed(ram_rdata);
    ext_upd = (didx_q == '0) ||
              ((mode_i == cnsc_pkg::MODE_BELOW) ? (key > ext_key_q) : (key < ext_key_q));
    hit     = (mode_i == cnsc_pkg::MODE_BELOW) ? (key < qval_q) : (key > qval_q);
    closer  = (mode_i == cnsc_pkg::MODE_BELOW) ? (key > best_key_q) : (key < best_key_q);
  end

  // rotation cost of the chosen neighbor
  always_comb begin
    tpos     = found_q ? best_q : ext_q;
    cost_sum = cnsc_pkg::SUM_W'(cnsc_pkg::side_cost(cnsc_pkg::SIDE_W'(qpos_q),
                                                    cnsc_pkg::SIDE_W'(qlen_q)))
             + cnsc_pkg::SUM_W'(cnsc_pkg::side_cost(cnsc_pkg::SIDE_W'(tpos),
                                                    cnsc_pkg::SIDE_W'(count_q)));
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    issue_d    = issue_q;
    dv_d       = 1'b0;
    didx_d     = didx_q;
    found_d    = found_q;
    best_d     = best_q;
    ext_d      = ext_q;
    best_key_d = best_key_q;
    ext_key_d  = ext_key_q;
    qval_d     = qval_q;
    qpos_d     = qpos_q;
    qlen_d     = qlen_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[AW-1:0];
    in_stall_o  = (state_q != cnsc_pkg::ST_IDLE);
    res_valid_o = 1'b0;

    unique case (state_q)
      cnsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = cnsc_pkg::ST_EMIT;
          unique case (in_word_i.req_type)
            cnsc_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            cnsc_pkg::REQ_LOAD: begin
              if (count_q < CW'(cnsc_pkg::STORE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                res_d.status = cnsc_pkg::STAT_FULL;
              end
            end
            cnsc_pkg::REQ_QUERY: begin
              if (count_q == '0) begin
                res_d.status = cnsc_pkg::STAT_EMPTY;
              end else begin
                qval_d  = in_word_i.item_value;
                qpos_d  = in_word_i.query_position;
                qlen_d  = in_word_i.query_list_length;
                issue_d = '0;
                found_d = 1'b0;
                state_d = cnsc_pkg::ST_SCAN;
              end
            end
            default: begin
              // unused request code: store left unchanged, all-zero result
            end
          endcase
        end
      end

      cnsc_pkg::ST_SCAN: begin
        // issue next read
        if (issue_q < count_q) begin
          dv_d    = 1'b1;
          didx_d  = issue_q[AW-1:0];
          issue_d = issue_q + CW'(1);
        end
        // fold in the entry read last cycle; ties keep the earlier entry
        if (dv_q) begin
          if (ext_upd) begin
            ext_d     = didx_q;
            ext_key_d = key;
          end
          if (hit && (!found_q || closer)) begin
            best_d     = didx_q;
            best_key_d = key;
            found_d    = 1'b1;
          end
        end else if (issue_q >= count_q) begin
          state_d = cnsc_pkg::ST_COST;
        end
      end

      cnsc_pkg::ST_COST: begin
        res_d.target_position = cnsc_pkg::TPOS_W'(tpos);
        res_d.move_cost = (cost_sum > cnsc_pkg::SUM_W'(cnsc_pkg::COST_CAP)) ?
                          cnsc_pkg::COST_CAP : cost_sum[cnsc_pkg::COST_W-1:0];
        res_d.status    = cnsc_pkg::STAT_OK;
        state_d         = cnsc_pkg::ST_EMIT;
      end

      cnsc_pkg::ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = cnsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cnsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== test/circular_neighbor_search_cost_core_tb.sv =====
// Testbench for circular_neighbor_search_cost_core: drives clear, load, query and unused-code words,
// predicts each result word from a local copy of the store and checks it field by field.
// Depends on cnsc_pkg and the block's RTL only.
`default_nettype none
module circular_neighbor_search_cost_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS  = 400;
  localparam int          LIMIT_CYCLES  = 2_000_000;
  localparam int          COST_LIMIT    = 512;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [2:0]  MODE_REG_ADDR = 3'd0;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  cnsc_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  cnsc_pkg::out_word_t out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  circular_neighbor_search_cost_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Local copy of the block's state
  logic signed [31:0] shadow_store [cnsc_pkg::STORE_DEPTH];
  int                 shadow_count;
  cnsc_pkg::mode_e    shadow_mode;

  cnsc_pkg::out_word_t pending_results [$];
  int        fail_count;
  int        items_sent;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        idle_on;
  bit        stall_on;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin : out_stall_gen
    int len;
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      len = stall_on ? pick_gap() : 0;
      if (len > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= len - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Shorter way around a circular list
  function automatic int rotation_cost(input int pos, input int len);
    if (pos <= len / 2) return pos;
    if (pos > len) return 0;
    return len - pos;
  endfunction

  // Closest smaller (or larger) stored value, wrapping to the extreme; first wins on ties
  function automatic int find_neighbor(input logic signed [31:0] q);
    int  best;
    int  ext;
    bit  found;
    logic signed [31:0] v;
    best  = 0;
    ext   = 0;
    found = 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      v = shadow_store[i];
      if (shadow_mode == cnsc_pkg::MODE_BELOW) begin
        if (v > shadow_store[ext]) ext = i;
        if (v < q && (!found || v > shadow_store[best])) begin
          best  = i;
          found = 1'b1;
        end
      end else begin
        if (v < shadow_store[ext]) ext = i;
        if (v > q && (!found || v < shadow_store[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
    end
    return found ? best : ext;
  endfunction

  // Updates the local store and returns the result word that the input word causes
  function automatic cnsc_pkg::out_word_t predict_search_result(input cnsc_pkg::in_word_t w);
    cnsc_pkg::out_word_t res;
    int        tpos;
    int        cost;
    res = '0;
    case (w.req_type)
      cnsc_pkg::REQ_CLEAR: begin
        shadow_count = 0;
      end
      cnsc_pkg::REQ_LOAD: begin
        if (shadow_count < cnsc_pkg::STORE_DEPTH) begin
          shadow_store[shadow_count] = w.item_value;
          shadow_count++;
        end else begin
          res.status = cnsc_pkg::STAT_FULL;
        end
      end
      cnsc_pkg::REQ_QUERY: begin
        if (shadow_count == 0) begin
          res.status = cnsc_pkg::STAT_EMPTY;
        end else begin
          tpos = find_neighbor(w.item_value);
          cost = rotation_cost(int'(w.query_position), int'(w.query_list_length))
               + rotation_cost(tpos, shadow_count);
          if (cost > COST_LIMIT) cost = COST_LIMIT;
          res.target_position = tpos[8:0];
          res.move_cost       = cost[9:0];
          res.status          = cnsc_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    cnsc_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: %h", out_word_o);
        fail_count++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_word_o.target_position !== exp_w.target_position) begin
          $error("target_position: expected %0d, got %0d",
                 exp_w.target_position, out_word_o.target_position);
          fail_count++;
        end
        if (out_word_o.move_cost !== exp_w.move_cost) begin
          $error("move_cost: expected %0d, got %0d", exp_w.move_cost, out_word_o.move_cost);
          fail_count++;
        end
        if (out_word_o.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_word_o.status);
          fail_count++;
        end
      end
    end
  end

  function automatic cnsc_pkg::in_word_t make_word(input logic [1:0] req,
                                                   input logic [31:0] val,
                                                   input logic [8:0] qpos,
                                                   input logic [9:0] qlen);
    cnsc_pkg::in_word_t w;
    w.req_type          = req;
    w.item_value        = val;
    w.query_position    = qpos;
    w.query_list_length = qlen;
    return w;
  endfunction

  // Small values give ties, full range and extremes give corner orderings
  function automatic logic [31:0] pick_value(input int style);
    int r;
    case (style)
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom;
      default: begin
        r = $urandom_range(0, 5);
        case (r)
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          4: return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
    endcase
  endfunction

  // Query near a stored value or anywhere, with varied positions and lengths
  function automatic cnsc_pkg::in_word_t random_query(input int style);
    logic [31:0] val;
    int          qpos;
    int          qlen;
    int          r;
    if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
      val = shadow_store[$urandom_range(0, shadow_count - 1)] + ($urandom_range(0, 2) - 1);
    end else begin
      val = pick_value(style);
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      qlen = $urandom_range(1, 512);
      qpos = $urandom_range(0, (qlen - 1 > 511) ? 511 : qlen - 1);
    end else if (r < 8) begin
      qpos = $urandom_range(0, 511);
      qlen = $urandom_range(0, 1023);
    end else begin
      qpos = $urandom_range(0, 511);
      qlen = $urandom_range(0, 512);
    end
    return make_word(cnsc_pkg::REQ_QUERY, val, qpos[8:0], qlen[9:0]);
  endfunction

  // Sends one word; valid stays high into the next call when no gap is drawn
  task automatic send_word(input cnsc_pkg::in_word_t w);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_search_result(w));
    if (w.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Stops sending and waits until every expected word has come back
  task automatic wait_results_done(input int tail);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_mode_readback();
    logic [31:0] rd;
    apb_read(MODE_REG_ADDR, rd);
    if (rd[0] !== shadow_mode) begin
      $error("search_mode readback: expected %0d, got %0d", shadow_mode, rd[0]);
      fail_count++;
    end
  endtask

  // Mode changes only while the block is idle
  task automatic write_mode(input cnsc_pkg::mode_e m);
    wait_results_done(4);
    apb_write(MODE_REG_ADDR, {31'd0, m});
    shadow_mode = m;
    check_mode_readback();
  endtask

  task automatic test_register_reset();
    check_mode_readback();
  endtask

  // Extremes, ties, empty store, wrap-around, past-the-end position, cost cap, unused type
  task automatic test_directed_cases();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd0, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_QUERY, VAL_MAX, 9'd511, 10'd1023));
    send_word(make_word(cnsc_pkg::REQ_LOAD, 32'd5, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_LOAD, VAL_MIN, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_LOAD, VAL_MAX, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_LOAD, 32'd5, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_LOAD, 32'hffff_ffff, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_LOAD, 32'd0, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd6, 9'd3, 10'd8));
    send_word(make_word(cnsc_pkg::REQ_QUERY, VAL_MIN, 9'd511, 10'd1023));
    send_word(make_word(cnsc_pkg::REQ_QUERY, VAL_MAX, 9'd0, 10'd512));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd0, 9'd9, 10'd4));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd5, 9'd256, 10'd512));
    send_word(make_word(REQ_UNUSED, VAL_MAX, 9'd511, 10'd1023));
    write_mode(cnsc_pkg::MODE_ABOVE);
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd4, 9'd1, 10'd2));
    send_word(make_word(cnsc_pkg::REQ_QUERY, VAL_MAX, 9'd511, 10'd1023));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'hffff_ffff, 9'd300, 10'd600));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd5, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_CLEAR, 32'd0, 9'd0, 10'd0));
    send_word(make_word(cnsc_pkg::REQ_QUERY, 32'd1, 9'd0, 10'd0));
    write_mode(cnsc_pkg::MODE_BELOW);
  endtask

  // Fills the store to the top, loads past it, and queries the full store
  task automatic test_full_store();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_word(make_word(cnsc_pkg::REQ_CLEAR, $urandom, 9'($urandom), 10'($urandom)));
    for (int i = 0; i < cnsc_pkg::STORE_DEPTH; i++) begin
      send_word(make_word(cnsc_pkg::REQ_LOAD, pick_value($urandom_range(0, 2)),
                          9'($urandom), 10'($urandom)));
    end
    repeat (3) begin
      send_word(make_word(cnsc_pkg::REQ_LOAD, pick_value(1), 9'($urandom), 10'($urandom)));
    end
    repeat (4) send_word(random_query($urandom_range(0, 2)));
    send_word(make_word(cnsc_pkg::REQ_QUERY, pick_value(1), 9'd511, 10'd1023));
    write_mode(cnsc_pkg::MODE_ABOVE);
    repeat (4) send_word(random_query($urandom_range(0, 2)));
    send_word(make_word(cnsc_pkg::REQ_QUERY, pick_value(1), 9'd256, 10'd512));
    send_word(make_word(cnsc_pkg::REQ_LOAD, pick_value(2), 9'($urandom), 10'($urandom)));
    send_word(make_word(cnsc_pkg::REQ_CLEAR, $urandom, 9'($urandom), 10'($urandom)));
    send_word(make_word(cnsc_pkg::REQ_LOAD, pick_value(2), 9'($urandom), 10'($urandom)));
    send_word(random_query(2));
    write_mode(cnsc_pkg::MODE_BELOW);
  endtask

  // Mostly clear / load / query runs with random content, some noise words between
  task automatic test_random_sequences();
    int seq_cnt;
    int base;
    int n;
    int style;
    seq_cnt = 0;
    base    = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      seq_cnt++;
      if (seq_cnt % 5 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      if (seq_cnt % 9 == 0) write_mode(cnsc_pkg::mode_e'($urandom_range(0, 1)));
      // hold off until the block has drained
      if (seq_cnt % 13 == 0) wait_results_done(0);
      if ($urandom_range(0, 9) < 7) begin
        style = $urandom_range(0, 2);
        send_word(make_word(cnsc_pkg::REQ_CLEAR, $urandom, 9'($urandom), 10'($urandom)));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        repeat (n) begin
          send_word(make_word(cnsc_pkg::REQ_LOAD, pick_value(style),
                              9'($urandom), 10'($urandom)));
        end
        repeat ($urandom_range(2, 8)) send_word(random_query(style));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(make_word(2'($urandom_range(0, 3)), pick_value($urandom_range(0, 2)),
                              9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023))));
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    shadow_count = 0;
    shadow_mode  = cnsc_pkg::MODE_BELOW;
    fail_count   = 0;
    items_sent   = 0;
    idle_on      = 1'b0;
    stall_on     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_cases();
    test_full_store();
    test_random_sequences();
    wait_results_done(20);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/cnsc_pkg.sv
src/cnsc_ram.sv
src/cnsc_engine.sv
src/circular_neighbor_search_cost_core.sv
test/circular_neighbor_search_cost_core_tb.sv
